// File: rtl/substring_stream_matcher_defines.svh
// Assertion macros used by the matcher RTL.
`ifndef SUBSTRING_STREAM_MATCHER_DEFINES_SVH
`define SUBSTRING_STREAM_MATCHER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond never holds outside reset.
`define SSM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/ssm_pkg.sv
`timescale 1ns / 1ps
package ssm_pkg;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned IDX_W  = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_W  = 6;
    localparam int unsigned CNT_W  = 32;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CFG_W-1:0]  t_cfg;
    typedef logic [CNT_W-1:0]  t_count;

    // Command codes
    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_TEXT = 2'd1;
    localparam t_cmd CMD_END  = 2'd2;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam t_count CNT_MAX      = '1;
    localparam t_count NO_MATCH_POS = '1;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic  shift;   // text byte enters, window advances one cell
        logic  rotate;  // pattern ring advances one cell
        t_byte data;    // incoming byte
    } t_cell_ctrl;

    // Item handed from the input handshake to the tally stage
    typedef struct packed {
        logic take;
        t_cmd cmd;
    } t_step;

endpackage

// File: rtl/ssm_in_if.sv
`timescale 1ns / 1ps
interface ssm_in_if import ssm_pkg::*; ;
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_idx  pattern_index;
    t_byte data_byte;

    modport source (output valid, output command, output pattern_index, output data_byte,
                    input ready);
    modport sink   (input valid, input command, input pattern_index, input data_byte,
                    output ready);
endinterface

// File: rtl/ssm_out_if.sv
`timescale 1ns / 1ps
interface ssm_out_if import ssm_pkg::*; ;
    logic   valid;
    logic   ready;
    logic   kind;
    t_count position;
    t_count match_count;
    logic   found;

    modport source (output valid, output kind, output position, output match_count,
                    output found, input ready);
    modport sink   (input valid, input kind, input position, input match_count,
                    input found, output ready);
endinterface

// File: rtl/ssm_cell.sv
`timescale 1ns / 1ps
module ssm_cell import ssm_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_load,
    input  t_byte      i_win,
    input  t_byte      i_pat,
    output t_byte      o_win,
    output t_byte      o_pat,
    output logic       o_eq
);

    t_byte r_win;
    t_byte r_pat;

    // Window tap and pattern ring slot; both are payload, no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= i_win;
        end
        if (i_load) begin
            r_pat <= i_ctrl.data;
        end else if (i_ctrl.rotate) begin
            r_pat <= i_pat;
        end
    end

    assign o_win = r_win;
    assign o_pat = r_pat;
    assign o_eq  = (r_win == r_pat);

endmodule

// File: rtl/ssm_tally.sv
`timescale 1ns / 1ps
module ssm_tally import ssm_pkg::*; #(
    parameter int unsigned PATTERN_MAX = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_step                               i_step,
    input  logic [PATTERN_MAX-1:0]              i_eq,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]    i_len,
    output logic                                o_can_take,
    ssm_out_if.source                           o_res
);

    localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

    logic   r_b_valid, n_b_valid;
    t_cmd   r_b_cmd, n_b_cmd;
    t_count r_pos, n_pos;
    t_count r_cnt, n_cnt;
    t_count r_first, n_first;
    logic   r_any, n_any;
    logic   r_o_valid, n_o_valid;
    logic   r_o_kind, n_o_kind;
    t_count r_o_position, n_o_position;
    t_count r_o_count, n_o_count;
    logic   r_o_found, n_o_found;

    logic                   out_free;
    logic                   adv;
    logic [PATTERN_MAX-1:0] cell_ok;
    logic                   all_ok;
    logic [CNT_W:0]         seen;
    logic [CNT_W:0]         start;
    logic                   len_zero;
    logic                   hit;
    t_count                 cnt_inc;

    always_comb begin
        // Cells past the pattern length do not take part
        for (int i = 0; i < PATTERN_MAX; i++) begin
            cell_ok[i] = i_eq[i] | (LW'(i) >= i_len);
        end
        all_ok   = &cell_ok;
        out_free = !r_o_valid || o_res.ready;
        adv      = r_b_valid && out_free;
        seen     = {1'b0, r_pos} + (CNT_W+1)'(1);
        start    = seen - (CNT_W+1)'(i_len);
        len_zero = (i_len == '0);
        hit      = len_zero || ((seen >= (CNT_W+1)'(i_len)) && all_ok);
        cnt_inc  = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);

        n_b_valid    = i_step.take ? 1'b1 : (adv ? 1'b0 : r_b_valid);
        n_b_cmd      = i_step.take ? i_step.cmd : r_b_cmd;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_any        = r_any;
        n_o_valid    = r_o_valid && !o_res.ready;
        n_o_kind     = r_o_kind;
        n_o_position = r_o_position;
        n_o_count    = r_o_count;
        n_o_found    = r_o_found;

        if (adv) begin
            case (r_b_cmd)
                CMD_TEXT: begin
                    n_pos = (r_pos == CNT_MAX) ? r_pos : r_pos + CNT_W'(1);
                    if (hit) begin
                        n_cnt = cnt_inc;
                        if (!r_any) begin
                            n_any   = 1'b1;
                            n_first = start[CNT_W-1:0];
                        end
                        n_o_valid    = 1'b1;
                        n_o_kind     = KIND_MATCH;
                        n_o_position = start[CNT_W-1:0];
                        n_o_count    = cnt_inc;
                        n_o_found    = 1'b1;
                    end
                end
                CMD_END: begin
                    n_o_valid    = 1'b1;
                    n_o_kind     = KIND_SUMMARY;
                    n_o_position = r_any ? r_first : (len_zero ? '0 : NO_MATCH_POS);
                    n_o_count    = r_cnt;
                    n_o_found    = r_any || len_zero;
                    n_pos        = '0;
                    n_cnt        = '0;
                    n_first      = '0;
                    n_any        = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_first   <= '0;
            r_any     <= 1'b0;
        end else begin
            r_b_valid <= n_b_valid;
            r_o_valid <= n_o_valid;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
            r_first   <= n_first;
            r_any     <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_cmd      <= n_b_cmd;
        r_o_kind     <= n_o_kind;
        r_o_position <= n_o_position;
        r_o_count    <= n_o_count;
        r_o_found    <= n_o_found;
    end

    assign o_can_take        = !r_b_valid || out_free;
    assign o_res.valid       = r_o_valid;
    assign o_res.kind        = r_o_kind;
    assign o_res.position    = r_o_position;
    assign o_res.match_count = r_o_count;
    assign o_res.found       = r_o_found;

endmodule

// File: rtl/substring_stream_matcher.sv
`timescale 1ns / 1ps
// Streaming substring matcher.
// i_in carries items: command 0 loads data_byte into pattern slot pattern_index,
// command 1 streams one text byte, command 2 ends the text. o_res carries results:
// a match report (kind 0, start position, running count) for each text byte that
// completes a match, and a summary (kind 1, first match, count, found) per end of
// text, after which the text counters restart. i_cfg_wr_en/i_cfg_wr_data write
// pattern_length; write it only while no item is in flight.
// On an input transfer the window and tally stage are loaded, and the result is then
// loaded into the output register once that register is free. Throughput: one item
// per cycle while the ring is aligned and the receiver takes results, set by the
// chain of compare cells that all test the window in parallel.
// After a pattern_length write the pattern ring rotates one cell a cycle into the
// new alignment; i_in.ready stays low until the ring is aligned.
// Reset (synchronous, active low) clears pattern_length, the counters and the
// handshake state; pattern bytes stay undefined until loaded.
// A stalled receiver holds the result in the output register; one more item may
// wait in the tally stage, then i_in.ready drops until the result transfers.
`include "substring_stream_matcher_defines.svh"
module substring_stream_matcher import ssm_pkg::*; #(
    parameter int unsigned PATTERN_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  t_cfg        i_cfg_wr_data,
    ssm_in_if.sink      i_in,
    ssm_out_if.source   o_res
);

    localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
    localparam int unsigned RW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;
    localparam int unsigned IW = (RW + 1 > IDX_W) ? RW + 1 : IDX_W;
    localparam logic [CW-1:0] P_CW   = CW'(PATTERN_MAX);
    localparam logic [IW-1:0] P_IW   = IW'(PATTERN_MAX);
    localparam logic [IW-1:0] PM1_IW = IW'(PATTERN_MAX - 1);
    localparam logic [LW-1:0] P_LW   = LW'(PATTERN_MAX);
    localparam logic [RW-1:0] LAST   = RW'(PATTERN_MAX - 1);

    // Configuration and ring alignment
    t_cfg          r_cfg;
    logic [RW-1:0] r_rot, n_rot;

    logic [CW-1:0] cfg_wide;
    logic [LW-1:0] eff_len;
    logic [RW-1:0] rot_target;
    logic          aligned;

    logic          can_take;
    logic          in_acc;
    logic [IW-1:0] slot_sum;
    logic [IW-1:0] slot_wrap;
    logic [RW-1:0] load_slot;
    logic          pidx_ok;
    logic          load_any;

    t_cell_ctrl             ctrl;
    t_step                  step;
    t_byte                  win [PATTERN_MAX];
    t_byte                  pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] load_we;

    // Cap the length at the number of cells. The ring holds slot i as pattern
    // byte (r_rot - 1 - i) mod PATTERN_MAX, so with r_rot equal to the length
    // mod PATTERN_MAX every cell compares its window byte to the right pattern byte.
    always_comb begin
        cfg_wide   = CW'(r_cfg);
        eff_len    = (cfg_wide > P_CW) ? P_LW : cfg_wide[LW-1:0];
        rot_target = (eff_len == P_LW) ? '0 : eff_len[RW-1:0];
        aligned    = (r_rot == rot_target);
        n_rot      = aligned ? r_rot : ((r_rot == LAST) ? '0 : r_rot + RW'(1));
    end

    // Handshake on the input side: hold off while the ring realigns or while the
    // tally stage cannot move on.
    assign i_in.ready = can_take && aligned;
    assign in_acc     = i_in.valid && i_in.ready;

    // Map a pattern index onto its ring slot; drop indexes past the last cell.
    always_comb begin
        pidx_ok   = (IW'(i_in.pattern_index) < P_IW);
        slot_sum  = IW'(r_rot) + PM1_IW - IW'(i_in.pattern_index);
        slot_wrap = (slot_sum >= P_IW) ? slot_sum - P_IW : slot_sum;
        load_slot = slot_wrap[RW-1:0];
        load_any  = in_acc && (i_in.command == CMD_LOAD) && pidx_ok;
    end

    always_comb begin
        ctrl.shift  = in_acc && (i_in.command == CMD_TEXT);
        ctrl.rotate = !aligned;
        ctrl.data   = i_in.data_byte;
        step.take   = in_acc;
        step.cmd    = i_in.command;
    end

    // Chain of cells: the window advances from cell 0 upward, the pattern ring
    // closes from the last cell back to cell 0.
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        t_byte win_in;
        t_byte pat_in;

        if (g == 0) begin : g_head
            assign win_in = ctrl.data;
            assign pat_in = pat[PATTERN_MAX-1];
        end else begin : g_body
            assign win_in = win[g-1];
            assign pat_in = pat[g-1];
        end

        assign load_we[g] = load_any && (load_slot == RW'(g));

        ssm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_load (load_we[g]),
            .i_win  (win_in),
            .i_pat  (pat_in),
            .o_win  (win[g]),
            .o_pat  (pat[g]),
            .o_eq   (eq[g])
        );
    end

    // Counters, match decision and output register
    ssm_tally #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_eq       (eq),
        .i_len      (eff_len),
        .o_can_take (can_take),
        .o_res      (o_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_rot <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_rot <= n_rot;
        end
    end

    // Checks
    `SSM_ASSERT_NEVER(a_no_shift_while_rotating, i_clk, i_rst_n,
        ctrl.shift && !aligned, "text byte entered while pattern ring realigns")
    `SSM_ASSERT_NEVER(a_no_load_while_rotating, i_clk, i_rst_n,
        load_any && !aligned, "pattern byte written while pattern ring realigns")
    `SSM_ASSERT_IMPLY(a_match_fields, i_clk, i_rst_n,
        o_res.valid && (o_res.kind == KIND_MATCH),
        o_res.found && (o_res.match_count != '0), "match report without found or count")
    `SSM_ASSERT_IMPLY(a_no_match_position, i_clk, i_rst_n,
        o_res.valid && (o_res.kind == KIND_SUMMARY) && !o_res.found,
        o_res.position == NO_MATCH_POS, "summary without match has a position")

endmodule

// File: tb/sv/substring_stream_matcher_checker.sv
`timescale 1ns / 1ps
module substring_stream_matcher_checker import ssm_pkg::*; #(
    parameter int unsigned PATTERN_MAX = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  t_cfg i_cfg_wr_data,
    ssm_in_if    i_in,
    ssm_out_if   i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_match_reports,
    output int   o_summaries
);

    localparam int unsigned MAX_PRINTED = 40;

    typedef struct packed {
        logic   kind;
        t_count position;
        t_count match_count;
        logic   found;
    } t_result;

    t_byte   pattern_mem [PATTERN_MAX];
    t_byte   window      [PATTERN_MAX];
    t_count  text_pos;
    t_count  hits;
    t_count  first_hit;
    logic    any_hit;
    t_cfg    length_reg;
    t_result expected_q [$];
    int      errors        = 0;
    int      match_reports = 0;
    int      summaries     = 0;

    function automatic int unsigned active_length();
        return (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
    endfunction

    function automatic void clear_text();
        for (int i = 0; i < PATTERN_MAX; i++) window[i] = '0;
        text_pos  = '0;
        hits      = '0;
        first_hit = '0;
        any_hit   = 1'b0;
    endfunction

    // Advance the matcher state by one item and queue the result it causes.
    function automatic void predict_result(t_cmd cmd, t_idx idx, t_byte data);
        int unsigned    len;
        logic [CNT_W:0] seen;
        logic           hit;
        t_result        r;
        len = active_length();
        case (cmd)
            CMD_LOAD: begin
                if (idx < PATTERN_MAX) pattern_mem[idx] = data;
            end
            CMD_TEXT: begin
                for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = data;
                seen = {1'b0, text_pos} + 1'b1;
                if (text_pos != CNT_MAX) text_pos = text_pos + 1'b1;
                if (len == 0) begin
                    hit = 1'b1;
                end else if (seen < len) begin
                    hit = 1'b0;
                end else begin
                    hit = 1'b1;
                    for (int j = 0; j < len; j++)
                        if (pattern_mem[j] != window[len-1-j]) hit = 1'b0;
                end
                if (hit) begin
                    if (hits != CNT_MAX) hits = hits + 1'b1;
                    r.kind        = KIND_MATCH;
                    r.position    = t_count'(seen - len);
                    r.match_count = hits;
                    r.found       = 1'b1;
                    if (!any_hit) begin
                        any_hit   = 1'b1;
                        first_hit = r.position;
                    end
                    expected_q.push_back(r);
                end
            end
            CMD_END: begin
                r.kind        = KIND_SUMMARY;
                r.match_count = hits;
                r.found       = any_hit || (len == 0);
                if (any_hit)
                    r.position = first_hit;
                else if (len == 0)
                    r.position = '0;
                else
                    r.position = NO_MATCH_POS;
                expected_q.push_back(r);
                clear_text();
            end
            default: ;
        endcase
    endfunction

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        string   diffs;
        if (!i_rst_n) begin
            for (int i = 0; i < PATTERN_MAX; i++) pattern_mem[i] = '0;
            length_reg = '0;
            clear_text();
            expected_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.kind        = i_res.kind;
                got.position    = i_res.position;
                got.match_count = i_res.match_count;
                got.found       = i_res.found;
                if (expected_q.size() == 0) begin
                    report_error($sformatf("unexpected result kind=%0d pos=%0d count=%0d",
                                           got.kind, got.position, got.match_count));
                end else begin
                    want  = expected_q.pop_front();
                    diffs = "";
                    if (got.kind !== want.kind)
                        diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
                    if (got.position !== want.position)
                        diffs = {diffs, $sformatf(" position %0d/%0d",
                                                  got.position, want.position)};
                    if (got.match_count !== want.match_count)
                        diffs = {diffs, $sformatf(" match_count %0d/%0d",
                                                  got.match_count, want.match_count)};
                    if (got.found !== want.found)
                        diffs = {diffs, $sformatf(" found %0d/%0d", got.found, want.found)};
                    if (diffs != "") report_error({"result mismatch (got/expected):", diffs});
                    if (want.kind == KIND_MATCH)
                        match_reports++;
                    else
                        summaries++;
                end
            end
            if (i_in.valid && i_in.ready)
                predict_result(i_in.command, i_in.pattern_index, i_in.data_byte);
            if (i_cfg_wr_en) length_reg = i_cfg_wr_data;
        end
        o_errors        <= errors;
        o_pending       <= expected_q.size();
        o_match_reports <= match_reports;
        o_summaries     <= summaries;
    end

endmodule

// File: tb/sv/tb_substring_stream_matcher.sv
`timescale 1ns / 1ps
module tb_substring_stream_matcher;
    import ssm_pkg::*;

    localparam int unsigned PATTERN_MAX = 32;
    localparam int unsigned ITEM_TARGET = 1050;
    // Covers the two-stage pipeline plus an item parked in the tally stage.
    localparam int unsigned TAIL_CYCLES = 10;
    localparam longint     TIMEOUT_NS   = 2_000_000;
    localparam int unsigned NUM_LENGTHS = 16;
    // Command 3 is unused; the block must swallow it without a result.
    localparam t_cmd        CMD_UNUSED  = 2'd3;

    // Pattern lengths per phase: empty, short, full, and above the cap.
    localparam t_cfg LENGTHS [NUM_LENGTHS] =
        '{6'd1, 6'd2, 6'd0, 6'd32, 6'd3, 6'd63, 6'd4, 6'd33,
          6'd2, 6'd5, 6'd1, 6'd12, 6'd3, 6'd32, 6'd0, 6'd7};

    typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    t_cfg cfg_wr_data;

    ssm_in_if  in_ch ();
    ssm_out_if res_ch ();

    int errors;
    int pending;
    int match_reports;
    int summaries;

    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned phase         = 0;

    // Mirror of the loaded pattern, used only to build texts that hit.
    t_byte       pat_mirror [PATTERN_MAX];
    t_byte       alphabet   [3];
    int unsigned alpha_n    = 1;

    substring_stream_matcher #(.PATTERN_MAX(PATTERN_MAX)) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_ch),
        .o_res        (res_ch)
    );

    substring_stream_matcher_checker #(.PATTERN_MAX(PATTERN_MAX)) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in           (in_ch),
        .i_res          (res_ch),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_match_reports(match_reports),
        .o_summaries    (summaries)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: drop ready at random at the current stall rate.
    always @(posedge clk) begin
        res_ch.ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
    end

    // Present one item and hold it until the block takes it. Valid stays high
    // into the next item unless an idle cycle is rolled, so it never toggles
    // twice in one step.
    task automatic send_item(t_cmd cmd, t_idx idx, t_byte data);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.pattern_index <= idx;
        in_ch.data_byte     <= data;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic load_byte(t_idx idx, t_byte data);
        send_item(CMD_LOAD, idx, data);
        pat_mirror[idx] = data;
    endtask

    // Release the input, wait until every predicted result has transferred,
    // then let the pipeline empty of items that carry no result.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(t_cfg value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct <= 0;  end
            IDLE_SENDER:   begin in_idle_pct = 49; out_stall_pct <= 0;  end
            IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct <= 49; end
            default:       begin in_idle_pct = 7;  out_stall_pct <= 7;  end
        endcase
    endtask

    // Mostly bytes from a tiny alphabet so that windows line up often,
    // with some fully random bytes as noise.
    function automatic t_byte pick_byte();
        if ($urandom_range(99) < 80) return alphabet[$urandom_range(alpha_n - 1)];
        return t_byte'($urandom_range(255));
    endfunction

    function automatic void new_alphabet();
        alpha_n = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) alphabet[i] = t_byte'($urandom_range(255));
    endfunction

    // Load entries 0..n-1 starting at a random rotation, so the order differs.
    task automatic load_pattern(int unsigned n);
        int unsigned rot;
        rot = $urandom_range(PATTERN_MAX - 1);
        for (int unsigned k = 0; k < n; k++)
            load_byte(t_idx'((k + rot) % n), alphabet[$urandom_range(alpha_n - 1)]);
    endtask

    // Stream one text and close it. Splice in whole copies of the pattern
    // for sure hits; sprinkle stray loads and unused commands.
    task automatic send_text(int unsigned eff, int unsigned nbytes);
        int unsigned i;
        int unsigned r;
        i = 0;
        while (i < nbytes) begin
            r = $urandom_range(99);
            if (eff > 0 && r < 15) begin
                for (int unsigned k = 0; k < eff; k++)
                    send_item(CMD_TEXT, t_idx'($urandom_range(31)), pat_mirror[k]);
                i += eff;
            end else if (r < 18) begin
                load_byte(t_idx'($urandom_range(31)), pick_byte());
            end else if (r < 20) begin
                send_item(CMD_UNUSED, t_idx'($urandom_range(31)), t_byte'($urandom_range(255)));
            end else begin
                send_item(CMD_TEXT, t_idx'($urandom_range(31)), pick_byte());
                i++;
            end
        end
        send_item(CMD_END, t_idx'($urandom_range(31)), t_byte'($urandom_range(255)));
    endtask

    initial begin
        t_cfg        len;
        int unsigned eff;
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_LOAD;
        in_ch.pattern_index = '0;
        in_ch.data_byte     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pattern after reset: every byte hits, at a position one past its index, and
        // the summary reports found at 0 even for an empty text.
        send_item(CMD_TEXT, 5'd0, 8'h00);
        send_item(CMD_TEXT, 5'd31, 8'hFF);
        send_item(CMD_END, 5'd0, 8'h00);
        send_item(CMD_END, 5'd0, 8'h00);
        send_item(CMD_UNUSED, 5'd31, 8'hFF);

        // Fill every pattern entry before any nonzero length can read one.
        new_alphabet();
        for (int unsigned k = 0; k < PATTERN_MAX; k++)
            load_byte(t_idx'(k), (k % 2 == 0) ? 8'h00 : 8'hFF);
        load_byte(5'd0, 8'h5A);

        // Single-byte pattern: two hits, then a text with no hit.
        write_length(6'd1);
        send_item(CMD_TEXT, 5'd0, 8'h5A);
        send_item(CMD_TEXT, 5'd0, 8'h00);
        send_item(CMD_TEXT, 5'd0, 8'h5A);
        send_item(CMD_END, 5'd0, 8'h00);
        send_item(CMD_TEXT, 5'd0, 8'hFF);
        send_item(CMD_END, 5'd0, 8'h00);

        // Length beyond the cap on an empty text: no hit, position all ones.
        write_length(6'd63);
        send_item(CMD_END, 5'd0, 8'h00);

        // Random phases: new length, new idle pattern, fresh pattern bytes,
        // then a handful of texts.
        while (items_sent < ITEM_TARGET) begin
            len = LENGTHS[phase % NUM_LENGTHS];
            eff = (len > PATTERN_MAX) ? PATTERN_MAX : len;
            new_alphabet();
            write_length(len);
            set_idle(t_idle_mode'(phase % 4));
            load_pattern(eff);
            repeat ($urandom_range(3, 6)) send_text(eff, $urandom_range(0, 2 * eff + 12));
            phase++;
        end

        drain();
        $display("Sent %0d items over %0d phases of pattern length and idle mix",
                 items_sent, phase);
        $display("Checked %0d match reports and %0d end-of-text summaries",
                 match_reports, summaries);
        if (errors == 0)
            $display("tb_substring_stream_matcher passed");
        else
            $display("tb_substring_stream_matcher failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_substring_stream_matcher failed");
        $finish;
    end

endmodule
